[design/mof_pkg.sv]
// ----------------------------------------------------------------------------
// mof_pkg
// Shared constants and types of the median-of-five sample filter.
// ----------------------------------------------------------------------------
package mof_pkg;

	localparam int WINDOW_SIZE  = 5;
	localparam int HIGH_W       = 8;
	localparam int LOW_W        = 4;
	localparam int SAMPLE_W     = HIGH_W + LOW_W;
	localparam int SLOT_W       = $clog2(WINDOW_SIZE);
	localparam int MEDIAN_INDEX = (WINDOW_SIZE - 1) / 2;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [SLOT_W-1:0]   slot_t;

	typedef struct packed {
		sample_t sample;
		slot_t   slot;
		logic    last;
	} mof_entry_t;

endpackage

[design/mof_if.sv]
// ----------------------------------------------------------------------------
// mof_sample_if / mof_median_if
// Valid/ready channels for incoming converter samples and outgoing medians.
// ----------------------------------------------------------------------------
interface mof_sample_if;
	import mof_pkg::*;

	logic              valid;
	logic              ready;
	logic [HIGH_W-1:0] sample_high;
	logic [LOW_W-1:0]  sample_low;

	modport source (output valid, output sample_high, output sample_low, input ready);
	modport sink   (input valid, input sample_high, input sample_low, output ready);
endinterface

interface mof_median_if;
	import mof_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] median_value;

	modport source (output valid, output median_value, input ready);
	modport sink   (input valid, input median_value, output ready);
endinterface

[design/median_of_five_sample_filter.sv]
// ----------------------------------------------------------------------------
// median_of_five_sample_filter
// Joins 8+4 bit converter samples, sorts each window of five as it fills
// and emits the median once per window.
//
//   channel   dir   fields                     request
//   samples   in    sample_high, sample_low    one converter sample
//   medians   out   median_value               one median per five samples
//
// One sample per cycle is accepted while the two-entry queue has room.
// A median becomes valid once its fifth sample has passed through the queue:
// the sample is held in the queue, and the sorted insert loads the output
// register as it leaves.
// Reset clears the slot counter, queue and output valid; window contents
// are not reset. A stalled median blocks the next window-closing sample and
// those queued behind it; earlier samples keep flowing into the window.
// ----------------------------------------------------------------------------
module median_of_five_sample_filter (
	input logic         clk,
	input logic         arst_n,
	mof_sample_if.sink  samples,
	mof_median_if.source medians
);
	import mof_pkg::*;

	logic       push;
	logic       push_ready;
	mof_entry_t push_entry;
	logic       pop;
	logic       pop_valid;
	mof_entry_t pop_entry;

	mof_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.push       (push),
		.push_entry (push_entry),
		.push_ready (push_ready)
	);

	mof_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_entry  (pop_entry),
		.pop        (pop)
	);

	mof_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_entry (pop_entry),
		.pop       (pop),
		.medians   (medians)
	);

endmodule

[design/mof_front.sv]
// ----------------------------------------------------------------------------
// mof_front
// Joins the sample halves, tags each request with its slot in the window
// and marks the one that completes it.
// ----------------------------------------------------------------------------
module mof_front (
	input  logic                clk,
	input  logic                arst_n,
	mof_sample_if.sink          samples,
	output logic                push,
	output mof_pkg::mof_entry_t push_entry,
	input  logic                push_ready
);
	import mof_pkg::*;

	slot_t slot_q;
	logic  is_last;

	assign is_last           = (slot_q == SLOT_W'(WINDOW_SIZE - 1));
	assign samples.ready     = push_ready;
	assign push              = samples.valid;
	assign push_entry.sample = {samples.sample_high, samples.sample_low};
	assign push_entry.slot   = slot_q;
	assign push_entry.last   = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (push && push_ready) begin
			slot_q <= is_last ? '0 : slot_q + SLOT_W'(1);
		end
	end

`ifndef NO_ASSERTIONS
	a_slot_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_ready && is_last) |=> (slot_q == '0))
		else $error("slot counter did not wrap after a full window");
`endif

endmodule

[design/mof_queue.sv]
// ----------------------------------------------------------------------------
// mof_queue
// Short queue between front and back so each side can stall on its own.
// ----------------------------------------------------------------------------
module mof_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mof_pkg::mof_entry_t push_entry,
	output logic                push_ready,
	output logic                pop_valid,
	output mof_pkg::mof_entry_t pop_entry,
	input  logic                pop
);
	import mof_pkg::*;

	mof_entry_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == QCNT_W'(QUEUE_DEPTH)) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");
`endif

endmodule

[design/mof_back.sv]
// ----------------------------------------------------------------------------
// mof_back
// Sorted-insert chain over the window; emits the middle entry when the
// window completes.
// ----------------------------------------------------------------------------
module mof_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	input  mof_pkg::mof_entry_t pop_entry,
	output logic                pop,
	mof_median_if.source        medians
);
	import mof_pkg::*;

	sample_t win_q   [WINDOW_SIZE];
	sample_t win_new [WINDOW_SIZE];
	logic    gtv     [WINDOW_SIZE];
	logic    med_valid_q;
	sample_t med_value_q;
	logic    back_ready;

	assign back_ready           = !pop_entry.last || !med_valid_q || medians.ready;
	assign pop                  = pop_valid && back_ready;
	assign medians.valid        = med_valid_q;
	assign medians.median_value = med_value_q;

	// entries at or past the slot are stale and ignored
	always_comb begin
		for (int i = 0; i < WINDOW_SIZE; i++) begin
			gtv[i] = (SLOT_W'(i) < pop_entry.slot) && (win_q[i] > pop_entry.sample);
		end
		win_new[0] = (gtv[0] || pop_entry.slot == '0) ? pop_entry.sample : win_q[0];
		for (int i = 1; i < WINDOW_SIZE; i++) begin
			if (gtv[i] || (SLOT_W'(i) == pop_entry.slot)) begin
				win_new[i] = gtv[i-1] ? win_q[i-1] : pop_entry.sample;
			end else begin
				win_new[i] = win_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			win_q <= win_new;
			if (pop_entry.last) begin
				med_value_q <= win_new[MEDIAN_INDEX];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			med_valid_q <= 1'b0;
		end else if (pop && pop_entry.last) begin
			med_valid_q <= 1'b1;
		end else if (medians.ready) begin
			med_valid_q <= 1'b0;
		end
	end

`ifndef NO_ASSERTIONS
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && pop_entry.last) |=> med_valid_q)
		else $error("completed window produced no median");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && pop_entry.last) |-> (!med_valid_q || medians.ready))
		else $error("pending median overwritten");
`endif

endmodule
